// ===== design/assert_macros.svh =====
// Assertion macros used by the checker in gwrd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gwrd_pkg.sv =====
package gwrd_pkg;

    localparam int BIN_COUNT  = 60;
    localparam int BIN_WIDTH  = 20;
    localparam int SLOT_W     = $clog2(BIN_COUNT);
    localparam int RUN_W      = BIN_WIDTH + $clog2(BIN_COUNT);
    localparam int IN_W       = 15;
    localparam int WIN_W      = 26;
    localparam int DOSE_W     = 48;
    localparam int PPB_W      = 8;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [BIN_WIDTH-1:0] BIN_MAX   = {BIN_WIDTH{1'b1}};
    localparam logic [WIN_W-1:0]     WIN_MAX   = {WIN_W{1'b1}};
    localparam logic [DOSE_W-1:0]    DOSE_MAX  = {DOSE_W{1'b1}};
    localparam logic [TICK_W-1:0]    TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [PPB_W-1:0]     PPB_RESET = 8'd10;
    localparam logic [TICK_W-1:0]    TONE_RESET = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALARM_ENABLE   = 3'd0,
        REG_POLLS_PER_BIN  = 3'd1,
        REG_RATE_THRESHOLD = 3'd2,
        REG_DOSE_THRESHOLD = 3'd3,
        REG_TONE_PERIOD    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic              alarm_enable;
        logic [PPB_W-1:0]  polls_per_bin;
        logic [WIN_W-1:0]  rate_threshold;
        logic [DOSE_W-1:0] dose_threshold;
        logic [TICK_W-1:0] tone_period;
    } cfg_t;

    // What the window unit reports for the tick being processed.
    typedef struct packed {
        logic                 closed;
        logic [BIN_WIDTH-1:0] closed_bin;
        logic [WIN_W-1:0]     win;
    } bin_result_t;

    typedef struct packed {
        logic tone_on;
        logic tone_select;
    } tone_t;

endpackage

// ===== design/gwrd_if.sv =====
interface gwrd_in_if;
    logic                     valid;
    logic                     ready;
    logic [gwrd_pkg::IN_W-1:0] counter_value;

    modport source (output valid, output counter_value, input ready);
    modport sink (input valid, input counter_value, output ready);
endinterface

interface gwrd_out_if;
    logic                        valid;
    logic                        ready;
    logic [gwrd_pkg::WIN_W-1:0]  window_count;
    logic [gwrd_pkg::WIN_W-1:0]  peak_count;
    logic [gwrd_pkg::DOSE_W-1:0] total_pulses;
    logic [gwrd_pkg::DOSE_W-1:0] dose_sum;
    logic                        bin_closed;
    logic                        tone_on;
    logic                        tone_select;

    modport source (output valid, output window_count, output peak_count,
                    output total_pulses, output dose_sum, output bin_closed,
                    output tone_on, output tone_select, input ready);
    modport sink (input valid, input window_count, input peak_count,
                  input total_pulses, input dose_sum, input bin_closed,
                  input tone_on, input tone_select, output ready);
endinterface

interface gwrd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gwrd_pkg::CFG_IDX_W-1:0]  index;
    logic [gwrd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/gwrd_cfg_regs.sv =====
module gwrd_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    gwrd_cfg_if.sink       cfg,
    output gwrd_pkg::cfg_t regs
);

    gwrd_pkg::cfg_t regs_reg;
    logic           wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.alarm_enable   <= 1'b0;
            regs_reg.polls_per_bin  <= gwrd_pkg::PPB_RESET;
            regs_reg.rate_threshold <= '0;
            regs_reg.dose_threshold <= '0;
            regs_reg.tone_period    <= gwrd_pkg::TONE_RESET;
        end
        else if (wr_en)
        begin
            // Writes to an index beyond the register list are dropped.
            unique case (cfg.index)
                gwrd_pkg::REG_ALARM_ENABLE:
                    regs_reg.alarm_enable <= cfg.data[0];
                gwrd_pkg::REG_POLLS_PER_BIN:
                    regs_reg.polls_per_bin <= cfg.data[gwrd_pkg::PPB_W-1:0];
                gwrd_pkg::REG_RATE_THRESHOLD:
                    regs_reg.rate_threshold <= cfg.data[gwrd_pkg::WIN_W-1:0];
                gwrd_pkg::REG_DOSE_THRESHOLD:
                    regs_reg.dose_threshold <= cfg.data[gwrd_pkg::DOSE_W-1:0];
                gwrd_pkg::REG_TONE_PERIOD:
                    regs_reg.tone_period <= cfg.data[gwrd_pkg::TICK_W-1:0];
                default:
                    regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// ===== design/gwrd_window.sv =====
module gwrd_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  logic [gwrd_pkg::IN_W-1:0]     diff,
    input  logic [gwrd_pkg::PPB_W-1:0]    polls_per_bin,
    output gwrd_pkg::bin_result_t         res
);

    logic [gwrd_pkg::PPB_W-1:0]     poll_count_reg, poll_count_next;
    logic [gwrd_pkg::BIN_WIDTH-1:0] open_bin_reg, open_bin_next;
    logic [gwrd_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [gwrd_pkg::RUN_W-1:0]     running_sum_reg, running_sum_next;
    logic [gwrd_pkg::BIN_COUNT-1:0] valid_reg;
    logic                           old_valid_reg;
    logic [gwrd_pkg::BIN_WIDTH-1:0] old_bin_reg;
    logic [gwrd_pkg::BIN_WIDTH-1:0] ring_mem [gwrd_pkg::BIN_COUNT];

    logic [gwrd_pkg::BIN_WIDTH:0]   open_sum;
    logic [gwrd_pkg::BIN_WIDTH-1:0] open_sat;
    logic [gwrd_pkg::BIN_WIDTH-1:0] old_bin;
    logic [gwrd_pkg::PPB_W-1:0]     poll_inc;
    logic [gwrd_pkg::PPB_W-1:0]     limit;
    logic                           close;
    logic [gwrd_pkg::RUN_W-1:0]     sum_closed;

    always_comb
    begin
        open_sum = {1'b0, open_bin_reg} + (gwrd_pkg::BIN_WIDTH + 1)'(diff);
        open_sat = open_sum[gwrd_pkg::BIN_WIDTH] ? gwrd_pkg::BIN_MAX
                                                 : open_sum[gwrd_pkg::BIN_WIDTH-1:0];
        poll_inc = poll_count_reg + gwrd_pkg::PPB_W'(1);
        limit    = (polls_per_bin == '0) ? gwrd_pkg::PPB_W'(1) : polls_per_bin;
        close    = (poll_inc == '0) || (poll_inc >= limit);

        // The slot about to be overwritten was prefetched on the previous edge.
        old_bin    = old_valid_reg ? old_bin_reg : '0;
        sum_closed = running_sum_reg - gwrd_pkg::RUN_W'(old_bin)
                     + gwrd_pkg::RUN_W'(open_sat);

        poll_count_next  = close ? '0 : poll_inc;
        open_bin_next    = close ? '0 : open_sat;
        running_sum_next = close ? sum_closed : running_sum_reg;
        if (close)
            slot_next = (slot_reg == gwrd_pkg::SLOT_W'(gwrd_pkg::BIN_COUNT - 1))
                        ? '0 : slot_reg + gwrd_pkg::SLOT_W'(1);
        else
            slot_next = slot_reg;

        res.closed     = close;
        res.closed_bin = open_sat;
        res.win = (running_sum_next > gwrd_pkg::RUN_W'(gwrd_pkg::WIN_MAX))
                  ? gwrd_pkg::WIN_MAX : gwrd_pkg::WIN_W'(running_sum_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_count_reg  <= '0;
            open_bin_reg    <= '0;
            slot_reg        <= '0;
            running_sum_reg <= '0;
            valid_reg       <= '0;
            old_valid_reg   <= 1'b0;
        end
        else
        begin
            if (tick)
            begin
                poll_count_reg  <= poll_count_next;
                open_bin_reg    <= open_bin_next;
                slot_reg        <= slot_next;
                running_sum_reg <= running_sum_next;
                if (close)
                    valid_reg[slot_reg] <= 1'b1;
                old_valid_reg <= valid_reg[slot_next];
            end
            else
            begin
                old_valid_reg <= valid_reg[slot_reg];
            end
        end
    end

    // Ring memory: one write at the closing slot, one registered read of
    // the slot that the next close will overwrite. The two never coincide.
    always_ff @(posedge clk)
    begin
        if (tick && close)
            ring_mem[slot_reg] <= open_sat;
        old_bin_reg <= ring_mem[tick ? slot_next : slot_reg];
    end

endmodule

// ===== design/gwrd_alarm.sv =====
module gwrd_alarm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  gwrd_pkg::cfg_t               regs,
    input  logic [gwrd_pkg::WIN_W-1:0]   win,
    input  logic [gwrd_pkg::DOSE_W-1:0]  dose,
    output gwrd_pkg::tone_t              tone
);

    logic                        phase_reg, phase_next;
    logic                        active_reg, active_next;
    logic [gwrd_pkg::TICK_W-1:0] ticks_reg, ticks_next;
    logic [gwrd_pkg::TICK_W-1:0] ticks_inc;
    logic                        cond;

    always_comb
    begin
        ticks_inc = (ticks_reg == gwrd_pkg::TICK_MAX) ? ticks_reg
                                                      : ticks_reg + gwrd_pkg::TICK_W'(1);
        cond = (win > regs.rate_threshold) || (dose > regs.dose_threshold);

        phase_next  = phase_reg;
        active_next = active_reg;
        ticks_next  = ticks_inc;
        priority if (!regs.alarm_enable || !cond)
        begin
            active_next = 1'b0;
        end
        else if (ticks_inc >= regs.tone_period)
        begin
            phase_next  = ~phase_reg;
            active_next = 1'b1;
            ticks_next  = '0;
        end
        else
        begin
            // Alarm still wanted but no alternation due: the tone keeps its state.
            active_next = active_reg;
        end

        tone.tone_on     = active_next;
        tone.tone_select = active_next & ~phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            active_reg <= 1'b0;
            ticks_reg  <= gwrd_pkg::TICK_MAX;
        end
        else if (tick)
        begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            ticks_reg  <= ticks_next;
        end
    end

endmodule

// ===== design/geiger_window_rate_dose_alarm_core.sv =====
// Sliding-window pulse-rate meter with dose accumulation and a two-tone alarm.
// sample: one beat per poll tick, carrying the raw free-running counter value.
// result: one beat per sample beat, in order: window count, peak, total of
//   closed bins, dose accumulator, the bin-closed flag and the tone outputs.
// cfg: register writes (index, data), always ready; write only while idle.
// A taken sample passes through the input stage and then the output register
// before it is presented on result. One sample is taken per cycle while
// result is not stalled; the bin ring, running sum and dose accumulator are
// updated as it leaves the input stage, with the next ring slot prefetched.
// An input stage and an output register part the channels, so a sample is
// still taken while a finished result waits; a stalled result holds its
// payload and the input stage fills before sample.ready drops.
// Reset clears all counters, the ring (through per-slot valid bits), the
// peak, totals and tone state, and loads the register defaults.
module geiger_window_rate_dose_alarm_core (
    input  logic         clk,
    input  logic         rst_n,
    gwrd_in_if.sink      sample,
    gwrd_out_if.source   result,
    gwrd_cfg_if.sink     cfg
);

    gwrd_pkg::cfg_t        regs;
    gwrd_pkg::bin_result_t bin_res;
    gwrd_pkg::tone_t       tone;

    logic                          s1_valid_reg;
    logic [gwrd_pkg::IN_W-1:0]     s1_diff_reg;
    logic [gwrd_pkg::IN_W-1:0]     last_reading_reg;
    logic                          take;
    logic                          adv;

    logic [gwrd_pkg::WIN_W-1:0]    peak_reg, peak_next;
    logic [gwrd_pkg::DOSE_W-1:0]   total_reg, total_next;
    logic [gwrd_pkg::DOSE_W-1:0]   dose_reg, dose_next;
    logic [gwrd_pkg::DOSE_W:0]     dose_sum;

    logic                          out_valid_reg;
    logic [gwrd_pkg::WIN_W-1:0]    out_win_reg;
    logic [gwrd_pkg::WIN_W-1:0]    out_peak_reg;
    logic [gwrd_pkg::DOSE_W-1:0]   out_total_reg;
    logic [gwrd_pkg::DOSE_W-1:0]   out_dose_reg;
    logic                          out_closed_reg;
    logic                          out_tone_on_reg;
    logic                          out_tone_sel_reg;

    assign adv          = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || adv;
    assign take         = sample.valid && sample.ready;

    gwrd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    gwrd_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (adv),
        .diff          (s1_diff_reg),
        .polls_per_bin (regs.polls_per_bin),
        .res           (bin_res)
    );

    gwrd_alarm u_alarm (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (adv),
        .regs  (regs),
        .win   (bin_res.win),
        .dose  (dose_next),
        .tone  (tone)
    );

    always_comb
    begin
        peak_next  = (bin_res.win > peak_reg) ? bin_res.win : peak_reg;
        total_next = bin_res.closed
                     ? total_reg + gwrd_pkg::DOSE_W'(bin_res.closed_bin) : total_reg;
        dose_sum   = {1'b0, dose_reg} + (gwrd_pkg::DOSE_W + 1)'(bin_res.win);
        dose_next  = dose_sum[gwrd_pkg::DOSE_W] ? gwrd_pkg::DOSE_MAX
                                                : dose_sum[gwrd_pkg::DOSE_W-1:0];
    end

    // Input stage: the clamped difference only depends on the previous
    // sample, so it is formed as the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            last_reading_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= take || (s1_valid_reg && !adv);
            if (take)
                last_reading_reg <= sample.counter_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_diff_reg <= (sample.counter_value > last_reading_reg)
                           ? sample.counter_value - last_reading_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            total_reg     <= '0;
            dose_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= adv || (out_valid_reg && !result.ready);
            if (adv)
            begin
                peak_reg  <= peak_next;
                total_reg <= total_next;
                dose_reg  <= dose_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_win_reg      <= bin_res.win;
            out_peak_reg     <= peak_next;
            out_total_reg    <= total_next;
            out_dose_reg     <= dose_next;
            out_closed_reg   <= bin_res.closed;
            out_tone_on_reg  <= tone.tone_on;
            out_tone_sel_reg <= tone.tone_select;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.window_count = out_win_reg;
    assign result.peak_count   = out_peak_reg;
    assign result.total_pulses = out_total_reg;
    assign result.dose_sum     = out_dose_reg;
    assign result.bin_closed   = out_closed_reg;
    assign result.tone_on      = out_tone_on_reg;
    assign result.tone_select  = out_tone_sel_reg;

endmodule

// ===== design/gwrd_checker.sv =====
`include "assert_macros.svh"

module gwrd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [gwrd_pkg::WIN_W-1:0]   window_count,
    input logic [gwrd_pkg::WIN_W-1:0]   peak_count,
    input logic [gwrd_pkg::DOSE_W-1:0]  dose_sum,
    input logic                         tone_on,
    input logic                         tone_select
);

    `CHK_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `CHK_NEXT(a_hold_data, clk, rst_n, out_valid && !out_ready, $stable({window_count, peak_count, dose_sum}), "result changed while stalled")
    `CHK_SAME(a_peak_ge_win, clk, rst_n, out_valid, peak_count >= window_count, "peak below window count")
    `CHK_SAME(a_select_off, clk, rst_n, out_valid && !tone_on, !tone_select, "tone select set with tone off")

endmodule

bind geiger_window_rate_dose_alarm_core gwrd_checker u_gwrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .window_count (result.window_count),
    .peak_count   (result.peak_count),
    .dose_sum     (result.dose_sum),
    .tone_on      (result.tone_on),
    .tone_select  (result.tone_select)
);

// ===== test/gwrd_meter_checker.sv =====
`timescale 1ns / 1ps

module gwrd_meter_checker
    import gwrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gwrd_in_if   sample,
    gwrd_out_if  result,
    gwrd_cfg_if  cfg,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic [WIN_W-1:0]  window_count;
        logic [WIN_W-1:0]  peak_count;
        logic [DOSE_W-1:0] total_pulses;
        logic [DOSE_W-1:0] dose_sum;
        logic              bin_closed;
        logic              tone_on;
        logic              tone_select;
    } meter_beat_t;

    localparam int MAX_REPORTS = 200;

    meter_beat_t          awaited_results [$];
    cfg_t                 regs;
    logic [IN_W-1:0]      prev_reading;
    logic [PPB_W-1:0]     polls_seen;
    logic [BIN_WIDTH-1:0] open_count;
    logic [BIN_WIDTH-1:0] ring_bins [BIN_COUNT];
    int                   ring_pos;
    logic [RUN_W:0]       window_sum;
    logic [WIN_W-1:0]     peak;
    logic [DOSE_W-1:0]    pulses;
    logic [DOSE_W-1:0]    dose;
    logic                 tone_phase;
    logic [TICK_W-1:0]    since_toggle;
    logic                 tone_live;
    int                   result_no;

    task automatic report_mismatch(input string line);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $time, line);
    endtask

    task automatic check_field(input string name, input logic [DOSE_W-1:0] got,
                               input logic [DOSE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result beat %0d: %s is 0x%0h, expected 0x%0h",
                                      result_no, name, got, want));
    endtask

    task automatic clear_meter();
        regs.alarm_enable   = 1'b0;
        regs.polls_per_bin  = PPB_RESET;
        regs.rate_threshold = '0;
        regs.dose_threshold = '0;
        regs.tone_period    = TONE_RESET;
        prev_reading = '0;
        polls_seen   = '0;
        open_count   = '0;
        foreach (ring_bins[i])
            ring_bins[i] = '0;
        ring_pos     = 0;
        window_sum   = '0;
        peak         = '0;
        pulses       = '0;
        dose         = '0;
        tone_phase   = 1'b0;
        since_toggle = TICK_MAX;
        tone_live    = 1'b0;
    endtask

    // One poll tick: bin the counter step, close the bin when due, then update
    // peak, dose and the alarm tone in that order.
    task automatic advance_meter(input logic [IN_W-1:0] reading, output meter_beat_t beat);
        logic [IN_W-1:0]    diff;
        logic [PPB_W-1:0]   limit;
        logic [BIN_WIDTH:0] bin_next;
        logic [WIN_W-1:0]   win;
        logic [DOSE_W:0]    dose_next;
        logic               closed;
        logic               alarm;

        diff  = (reading > prev_reading) ? reading - prev_reading : '0;
        limit = (regs.polls_per_bin == '0) ? PPB_W'(1) : regs.polls_per_bin;
        prev_reading = reading;

        bin_next   = {1'b0, open_count} + diff;
        open_count = bin_next[BIN_WIDTH] ? BIN_MAX : bin_next[BIN_WIDTH-1:0];

        closed     = 1'b0;
        polls_seen = polls_seen + 1'b1;
        if (polls_seen == '0 || polls_seen >= limit)
        begin
            window_sum = window_sum - ring_bins[ring_pos] + open_count;
            ring_bins[ring_pos] = open_count;
            ring_pos   = (ring_pos + 1 == BIN_COUNT) ? 0 : ring_pos + 1;
            pulses     = pulses + open_count;
            open_count = '0;
            polls_seen = '0;
            closed     = 1'b1;
        end

        win = (window_sum > WIN_MAX) ? WIN_MAX : window_sum[WIN_W-1:0];
        if (win > peak)
            peak = win;
        dose_next = {1'b0, dose} + win;
        dose      = dose_next[DOSE_W] ? DOSE_MAX : dose_next[DOSE_W-1:0];

        if (since_toggle != TICK_MAX)
            since_toggle = since_toggle + 1'b1;

        alarm = (win > regs.rate_threshold) || (dose > regs.dose_threshold);
        if (!regs.alarm_enable || !alarm)
            tone_live = 1'b0;
        else if (since_toggle >= regs.tone_period)
        begin
            tone_phase   = ~tone_phase;
            tone_live    = 1'b1;
            since_toggle = '0;
        end

        beat.window_count = win;
        beat.peak_count   = peak;
        beat.total_pulses = pulses;
        beat.dose_sum     = dose;
        beat.bin_closed   = closed;
        beat.tone_on      = tone_live;
        beat.tone_select  = tone_live ? ~tone_phase : 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        meter_beat_t want;
        meter_beat_t got;

        if (!rst_n)
        begin
            clear_meter();
            awaited_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ALARM_ENABLE:   regs.alarm_enable   = cfg.data[0];
                    REG_POLLS_PER_BIN:  regs.polls_per_bin  = cfg.data[PPB_W-1:0];
                    REG_RATE_THRESHOLD: regs.rate_threshold = cfg.data[WIN_W-1:0];
                    REG_DOSE_THRESHOLD: regs.dose_threshold = cfg.data[DOSE_W-1:0];
                    REG_TONE_PERIOD:    regs.tone_period    = cfg.data[TICK_W-1:0];
                    default: ;
                endcase
            end

            if (sample.valid && sample.ready)
            begin
                advance_meter(sample.counter_value, want);
                awaited_results.push_back(want);
            end

            if (result.valid && result.ready)
            begin
                got.window_count = result.window_count;
                got.peak_count   = result.peak_count;
                got.total_pulses = result.total_pulses;
                got.dose_sum     = result.dose_sum;
                got.bin_closed   = result.bin_closed;
                got.tone_on      = result.tone_on;
                got.tone_select  = result.tone_select;
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result beat %0d arrived with nothing awaited",
                                              result_no));
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("window_count", DOSE_W'(got.window_count),
                                DOSE_W'(want.window_count));
                    check_field("peak_count", DOSE_W'(got.peak_count),
                                DOSE_W'(want.peak_count));
                    check_field("total_pulses", got.total_pulses, want.total_pulses);
                    check_field("dose_sum", got.dose_sum, want.dose_sum);
                    check_field("bin_closed", DOSE_W'(got.bin_closed),
                                DOSE_W'(want.bin_closed));
                    check_field("tone_on", DOSE_W'(got.tone_on), DOSE_W'(want.tone_on));
                    check_field("tone_select", DOSE_W'(got.tone_select),
                                DOSE_W'(want.tone_select));
                end
                result_no++;
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ===== test/tb_geiger_window_rate_dose_alarm_core.sv =====
`timescale 1ns / 1ps

module tb_geiger_window_rate_dose_alarm_core;
    import gwrd_pkg::*;

    typedef enum int {PAT_STEADY, PAT_SPIKY, PAT_SAWTOOTH, PAT_NOISE} pulse_pattern_t;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_CHOKED} stall_pattern_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 3'd7;
    localparam logic [IN_W-1:0]      READING_MAX      = '1;
    localparam int                   RANDOM_READINGS  = 1800;

    logic            clk;
    logic            rst_n;
    int              mismatches;
    int              pending;
    int              burst_left;
    bit              no_gaps;
    bit              saw_high;
    logic [IN_W-1:0] reading;
    stall_pattern_t  stall_mode;
    int              mode_left;
    int              stall_tick;

    gwrd_in_if  sample_ch ();
    gwrd_out_if result_ch ();
    gwrd_cfg_if cfg_ch ();

    geiger_window_rate_dose_alarm_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    gwrd_meter_checker meter_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver switches between open, lightly stalled, half-rate and
    // heavily choked stretches of random length.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= stall_pattern_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 160);
        end
        else
            mode_left <= mode_left - 1;
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            RX_OPEN:  result_ch.ready <= 1'b1;
            RX_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  result_ch.ready <= 1'($urandom_range(0, 1));
            default:  result_ch.ready <= ((stall_tick % 16) >= 12);
        endcase
    end

    task automatic send_reading(input logic [IN_W-1:0] value);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_ch.valid         <= 1'b1;
        sample_ch.counter_value <= value;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    // Leaves cfg_ch.valid high so that back-to-back writes need no drop.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s, input bit poke_unmapped);
        write_register(REG_ALARM_ENABLE, CFG_DATA_W'(s.alarm_enable));
        write_register(REG_POLLS_PER_BIN, CFG_DATA_W'(s.polls_per_bin));
        write_register(REG_RATE_THRESHOLD, CFG_DATA_W'(s.rate_threshold));
        write_register(REG_DOSE_THRESHOLD, CFG_DATA_W'(s.dose_threshold));
        write_register(REG_TONE_PERIOD, CFG_DATA_W'(s.tone_period));
        if (poke_unmapped)
            write_register(CFG_IDX_UNMAPPED, CFG_DATA_W'({$urandom, $urandom}));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic cfg_t pick_settings();
        cfg_t s;

        s.alarm_enable = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 4))
            0:       s.polls_per_bin = '0;
            1:       s.polls_per_bin = 8'd1;
            2:       s.polls_per_bin = '1;
            default: s.polls_per_bin = PPB_W'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 4))
            0:       s.rate_threshold = '0;
            1:       s.rate_threshold = WIN_MAX;
            2:       s.rate_threshold = WIN_W'($urandom);
            default: s.rate_threshold = WIN_W'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 4))
            0:       s.dose_threshold = '0;
            1:       s.dose_threshold = DOSE_MAX;
            2:       s.dose_threshold = DOSE_W'({$urandom, $urandom});
            default: s.dose_threshold = DOSE_W'($urandom_range(0, 400000));
        endcase
        case ($urandom_range(0, 4))
            0:       s.tone_period = '0;
            1:       s.tone_period = 8'd1;
            2:       s.tone_period = TICK_MAX;
            3:       s.tone_period = TICK_W'($urandom_range(0, 255));
            default: s.tone_period = TICK_W'($urandom_range(2, 6));
        endcase
        return s;
    endfunction

    // Counter readings as a detector would produce them, plus full-scale
    // sawtooth steps that fill a bin and plain noise.
    function automatic logic [IN_W-1:0] next_reading(input pulse_pattern_t pattern);
        case (pattern)
            PAT_STEADY:
                reading = reading + IN_W'($urandom_range(0, 25));
            PAT_SPIKY:
                case ($urandom_range(0, 15))
                    0:       reading = reading + IN_W'($urandom_range(1000, 32767));
                    1:       reading = reading - IN_W'($urandom_range(1, 500));
                    default: reading = reading + IN_W'($urandom_range(0, 5));
                endcase
            PAT_SAWTOOTH:
            begin
                saw_high = !saw_high;
                reading  = saw_high ? READING_MAX - IN_W'($urandom_range(0, 3))
                                    : IN_W'($urandom_range(0, 3));
            end
            default:
                reading = IN_W'($urandom_range(0, 32767));
        endcase
        return reading;
    endfunction

    initial
    begin
        logic [IN_W-1:0] warmup [10] = '{15'd0, 15'd32767, 15'd0, 15'd32767, 15'd1,
                                         15'd0, 15'd16384, 15'd16383, 15'd32767, 15'd32766};
        logic [IN_W-1:0] slow_bins [4] = '{15'd100, 15'd2000, 15'd30000, 15'd32767};
        logic [IN_W-1:0] short_bins [4] = '{15'd0, 15'd5, 15'd10, 15'd15};
        logic [IN_W-1:0] every_tick [4] = '{15'd20, 15'd32767, 15'd32767, 15'd0};
        cfg_t            settings;
        pulse_pattern_t  pattern;
        int              sent;
        int              phase_len;
        int              pick;

        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.counter_value = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        result_ch.ready         = 1'b0;
        stall_mode              = RX_OPEN;
        mode_left               = 0;
        stall_tick              = 0;
        burst_left              = 0;
        no_gaps                 = 1'b0;
        saw_high                = 1'b0;
        reading                 = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults with the alarm off: full-scale steps and steps backwards.
        foreach (warmup[i])
            send_reading(warmup[i]);
        drain_results();

        // Long bins; leaves four polls in the open bin for the next setting.
        apply_settings('{1'b1, 8'd255, 26'd0, DOSE_MAX, TICK_MAX}, 1'b0);
        foreach (slow_bins[i])
            send_reading(slow_bins[i]);
        drain_results();

        // Bin length lowered below the polls already taken: closes on the next tick.
        apply_settings('{1'b1, 8'd2, WIN_MAX, '0, 8'd1}, 1'b0);
        foreach (short_bins[i])
            send_reading(short_bins[i]);
        drain_results();

        // Zero bin length and zero tone period, and a write to an unmapped index.
        apply_settings('{1'b1, 8'd0, WIN_MAX, '0, 8'd0}, 1'b1);
        foreach (every_tick[i])
            send_reading(every_tick[i]);

        reading = every_tick[3];
        sent    = 0;
        while (sent < RANDOM_READINGS)
        begin
            drain_results();
            pick = $urandom_range(0, 9);
            pattern = (pick < 4) ? PAT_STEADY :
                      (pick < 7) ? PAT_SPIKY :
                      (pick < 9) ? PAT_SAWTOOTH : PAT_NOISE;
            settings  = pick_settings();
            phase_len = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 500)
                                                     : $urandom_range(40, 200);
            // Half the sawtooth phases use long bins so that the open bin saturates.
            if (pattern == PAT_SAWTOOTH && $urandom_range(0, 1) == 1)
            begin
                settings.polls_per_bin = PPB_W'($urandom_range(64, 255));
                phase_len = $urandom_range(150, 300);
            end
            apply_settings(settings, $urandom_range(0, 7) == 0);
            no_gaps = ($urandom_range(0, 4) == 0);
            repeat (phase_len)
            begin
                send_reading(next_reading(pattern));
                sent++;
            end
        end
        drain_results();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/gwrd_pkg.sv
design/gwrd_if.sv
design/gwrd_cfg_regs.sv
design/gwrd_window.sv
design/gwrd_alarm.sv
design/geiger_window_rate_dose_alarm_core.sv
design/gwrd_checker.sv
test/gwrd_meter_checker.sv
test/tb_geiger_window_rate_dose_alarm_core.sv
